### sv/psf_weighted_downsample_core_defines.svh
// Assertion macros for the PSF weighted downsampler
`ifndef PSF_WEIGHTED_DOWNSAMPLE_CORE_DEFINES_SVH
`define PSF_WEIGHTED_DOWNSAMPLE_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset
`define PSFWD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define PSFWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/psfwd_pkg.sv
// Types and constants shared by the PSF weighted downsampler
package psfwd_pkg;

    localparam int HR_SIDE_DEF    = 128;
    localparam int PSF_SIDE_DEF   = 128;
    localparam int MAX_RADIUS_DEF = 7;

    localparam int FRAC_BITS = 9;
    localparam int POS_W     = 20;
    localparam int CFG_IW    = 3;
    localparam int CFG_DW    = 12;

    localparam logic [1:0] MODE_LOAD_IMG = 2'd0;
    localparam logic [1:0] MODE_LOAD_PSF = 2'd1;
    localparam logic [1:0] MODE_COMPUTE  = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    localparam logic [CFG_IW-1:0] CFG_SCALE     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_TAP_RATE  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_RADIUS_X  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_RADIUS_Y  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_HR_ROWS   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_HR_COLS   = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [6:0]  row;
        logic [6:0]  col;
        logic [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] lr_value;
        logic [6:0]  lr_row;
        logic [6:0]  lr_col;
    } t_out_item;

endpackage

### sv/psf_weighted_downsample_core.sv
// PSF weighted downsampler: image and table stores, window sequencer, MAC pipeline
//
// Load items (mode 0 image pixel, mode 1 table coefficient) are taken while idle.
// A compute item (mode 2) walks a (2*radius_y+4) row by (2*radius_x+4) column
// window around the output pixel centre. Each window row passes a row state for
// its table row index and then a column state per column through a shared
// index/multiply-accumulate pipeline. The next item can be taken in the cycle
// after the result is registered for the output; the input is not ready while
// the window runs, and longer still while an earlier result waits on the output;
// load items are still taken while an earlier result waits on the output. Both
// stores are arrays with one write port and one registered read port and need
// no clearing after reset; entries must be written before any compute item
// reads them.
module psf_weighted_downsample_core #(
    parameter int HR_SIDE    = psfwd_pkg::HR_SIDE_DEF,
    parameter int PSF_SIDE   = psfwd_pkg::PSF_SIDE_DEF,
    parameter int MAX_RADIUS = psfwd_pkg::MAX_RADIUS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  psfwd_pkg::t_in_item            i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output psfwd_pkg::t_out_item           o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [psfwd_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [psfwd_pkg::CFG_DW-1:0]   i_cfg_data
);

`include "psf_weighted_downsample_core_defines.svh"

    localparam int FB    = psfwd_pkg::FRAC_BITS;
    localparam int POSW  = psfwd_pkg::POS_W;
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int KW    = $clog2(2 * MAX_RADIUS + 4);
    localparam int LW    = $clog2(HR_SIDE + 1);
    localparam int HRW   = $clog2(HR_SIDE);
    localparam int PXW   = $clog2(PSF_SIDE);
    localparam int PW    = POSW - FB + KW + 2;
    localparam int OW    = PW + FB + 1;
    localparam int OFW   = $clog2((2 * MAX_RADIUS + 1) * (1 << FB));
    localparam int IXW   = OFW + 7 - FB;
    localparam int IAW   = $clog2(HR_SIDE * HR_SIDE);
    localparam int PAW   = $clog2(PSF_SIDE * PSF_SIDE);
    localparam int NTERM = (2 * MAX_RADIUS + 4) * (2 * MAX_RADIUS + 4);
    localparam int AW    = 32 + $clog2(NTERM + 1);

    typedef enum logic [1:0] {S_IDLE, S_ROW, S_COL, S_DRAIN} t_state;

    // configuration
    logic [11:0] r_scale_q8;
    logic [6:0]  r_tap_rate;
    logic [2:0]  r_radius_x;
    logic [2:0]  r_radius_y;
    logic [7:0]  r_hr_rows;
    logic [7:0]  r_hr_cols;

    // sequencer
    t_state              r_state;
    logic [POSW-1:0]     r_pos_y;
    logic [POSW-1:0]     r_pos_x;
    logic [RW-1:0]       r_rx;
    logic [RW-1:0]       r_ry;
    logic [LW-1:0]       r_rows;
    logic [LW-1:0]       r_cols;
    logic [KW-1:0]       r_ky;
    logic [KW-1:0]       r_kx;
    logic [6:0]          r_lr_row;
    logic [6:0]          r_lr_col;
    logic                r_out_valid;
    psfwd_pkg::t_out_item r_out_data;

    logic in_acc, c_emit, c_x_end, c_y_end;
    logic [RW-1:0] c_rx_cl, c_ry_cl;
    logic [LW-1:0] c_rows_cl, c_cols_cl;

    // coordinate stage
    logic                  c_is_row;
    logic [POSW-1:0]       c_pos;
    logic [RW-1:0]         c_r;
    logic [KW-1:0]         c_k;
    logic [LW-1:0]         c_lim;
    logic signed [PW-1:0]  c_p;
    logic signed [PW-1:0]  c_q;
    logic signed [OW-1:0]  c_off;
    logic [OW-1:0]         c_top;
    logic                  c_lim_ok, c_off_ok;
    logic [OW-1:0]         c_off_adj;

    logic            r_s0_act, r_s0_row, r_s0_ok, r_s0_last;
    logic [OFW-1:0]  r_s0_off;
    logic [HRW-1:0]  r_s0_p;

    // index stage
    logic [OFW+6:0]  c_iprod;
    logic [IXW-1:0]  c_idx;
    logic            c_idx_ok;
    logic [PXW-1:0]  r_ty;
    logic [HRW-1:0]  r_py;
    logic            r_yok;
    logic            r_s1_act, r_s1_ok, r_s1_last;
    logic [PXW-1:0]  r_s1_ty, r_s1_tx;
    logic [HRW-1:0]  r_s1_py, r_s1_px;

    // read, multiply, accumulate
    logic [15:0]     img_mem [HR_SIDE * HR_SIDE];
    logic [15:0]     psf_mem [PSF_SIDE * PSF_SIDE];
    logic [IAW-1:0]  c_img_wa, c_img_ra;
    logic [PAW-1:0]  c_psf_wa, c_psf_ra;
    logic            c_img_we, c_psf_we;
    logic [15:0]     r_img_q, r_psf_q;
    logic            r_s2_act, r_s2_ok, r_s2_last;
    logic [31:0]     r_prod;
    logic            r_s3_act, r_s3_last;
    logic [AW-1:0]   r_acc;
    logic [AW-1:0]   c_sum;
    logic [31:0]     r_res;
    logic            r_res_rdy;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // clamp radius and image size to what the stores and window support
    always_comb begin
        c_rx_cl   = (32'(r_radius_x) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_radius_x);
        c_ry_cl   = (32'(r_radius_y) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_radius_y);
        c_rows_cl = (32'(r_hr_rows) > HR_SIDE) ? LW'(HR_SIDE) : LW'(r_hr_rows);
        c_cols_cl = (32'(r_hr_cols) > HR_SIDE) ? LW'(HR_SIDE) : LW'(r_hr_cols);
    end

    assign c_x_end = (r_kx == KW'({r_rx, 1'b1}) + KW'(2));
    assign c_y_end = (r_ky == KW'({r_ry, 1'b1}) + KW'(2));
    assign c_emit  = (r_state == S_DRAIN) && r_res_rdy && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_q8  <= 12'd512;
            r_tap_rate  <= 7'd8;
            r_radius_x  <= 3'd1;
            r_radius_y  <= 3'd1;
            r_hr_rows   <= 8'd128;
            r_hr_cols   <= 8'd128;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                psfwd_pkg::CFG_SCALE:     r_scale_q8  <= i_cfg_data;
                psfwd_pkg::CFG_TAP_RATE:  r_tap_rate  <= i_cfg_data[6:0];
                psfwd_pkg::CFG_RADIUS_X:  r_radius_x  <= i_cfg_data[2:0];
                psfwd_pkg::CFG_RADIUS_Y:  r_radius_y  <= i_cfg_data[2:0];
                psfwd_pkg::CFG_HR_ROWS:   r_hr_rows   <= i_cfg_data[7:0];
                psfwd_pkg::CFG_HR_COLS:   r_hr_cols   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ky        <= '0;
            r_kx        <= '0;
        end else begin
            if (c_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_data.mode == psfwd_pkg::MODE_COMPUTE) begin
                        r_pos_y  <= POSW'({i_in_data.row, 1'b1}) * POSW'(r_scale_q8);
                        r_pos_x  <= POSW'({i_in_data.col, 1'b1}) * POSW'(r_scale_q8);
                        r_rx     <= c_rx_cl;
                        r_ry     <= c_ry_cl;
                        r_rows   <= c_rows_cl;
                        r_cols   <= c_cols_cl;
                        r_lr_row <= i_in_data.row;
                        r_lr_col <= i_in_data.col;
                        r_ky     <= '0;
                        r_state  <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_kx    <= '0;
                    r_state <= S_COL;
                end
                S_COL: begin
                    if (c_x_end) begin
                        if (c_y_end) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_ky    <= r_ky + KW'(1);
                            r_state <= S_ROW;
                        end
                    end else begin
                        r_kx <= r_kx + KW'(1);
                    end
                end
                S_DRAIN: begin
                    if (c_emit) begin
                        r_out_data.lr_value <= r_res;
                        r_out_data.lr_row   <= r_lr_row;
                        r_out_data.lr_col   <= r_lr_col;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // coordinate stage: window pixel, range checks, table offset in Q.9
    always_comb begin
        c_is_row  = (r_state == S_ROW);
        c_pos     = c_is_row ? r_pos_y : r_pos_x;
        c_r       = c_is_row ? r_ry : r_rx;
        c_k       = c_is_row ? r_ky : r_kx;
        c_lim     = c_is_row ? r_rows : r_cols;
        c_p       = PW'(c_pos >> FB) - PW'(c_r) - PW'(1) + PW'(c_k);
        c_q       = c_p - PW'(c_r);
        c_off     = OW'(c_pos) - (OW'(c_q) <<< FB);
        c_top     = OW'({c_r, 1'b1}) << FB;
        c_lim_ok  = !c_p[PW-1] && (c_p[PW-2:0] < (PW-1)'(c_lim));
        c_off_ok  = !c_off[OW-1] && ($unsigned(c_off) <= c_top);
        // far edge: pull an offset of exactly 2r+1 down by one LSB
        c_off_adj = ($unsigned(c_off) == c_top) ? $unsigned(c_off) - OW'(1) : $unsigned(c_off);
    end

    always_comb begin
        c_iprod  = (OFW + 7)'(r_s0_off) * (OFW + 7)'(r_tap_rate);
        c_idx    = c_iprod[OFW+6:FB];
        c_idx_ok = (32'(c_idx) < PSF_SIDE);
    end

    always_comb begin
        c_img_we = in_acc && (i_in_data.mode == psfwd_pkg::MODE_LOAD_IMG)
                   && (32'(i_in_data.row) < HR_SIDE) && (32'(i_in_data.col) < HR_SIDE);
        c_psf_we = in_acc && (i_in_data.mode == psfwd_pkg::MODE_LOAD_PSF)
                   && (32'(i_in_data.row) < PSF_SIDE) && (32'(i_in_data.col) < PSF_SIDE);
        c_img_wa = IAW'(i_in_data.row) * IAW'(HR_SIDE) + IAW'(i_in_data.col);
        c_psf_wa = PAW'(i_in_data.row) * PAW'(PSF_SIDE) + PAW'(i_in_data.col);
        c_img_ra = IAW'(r_s1_py) * IAW'(HR_SIDE) + IAW'(r_s1_px);
        c_psf_ra = PAW'(r_s1_ty) * PAW'(PSF_SIDE) + PAW'(r_s1_tx);
        c_sum    = r_acc + AW'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (c_img_we) begin
            img_mem[c_img_wa] <= i_in_data.value;
        end
        r_img_q <= img_mem[c_img_ra];
    end

    always_ff @(posedge i_clk) begin
        if (c_psf_we) begin
            psf_mem[c_psf_wa] <= i_in_data.value;
        end
        r_psf_q <= psf_mem[c_psf_ra];
    end

    // shared index and multiply-accumulate pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_act  <= 1'b0;
            r_s1_act  <= 1'b0;
            r_s2_act  <= 1'b0;
            r_s3_act  <= 1'b0;
            r_yok     <= 1'b0;
            r_res_rdy <= 1'b0;
            r_acc     <= '0;
        end else begin
            r_s0_act  <= (r_state == S_ROW) || (r_state == S_COL);
            r_s0_row  <= c_is_row;
            r_s0_ok   <= c_lim_ok && c_off_ok;
            r_s0_last <= (r_state == S_COL) && c_x_end && c_y_end;
            r_s0_off  <= OFW'(c_off_adj);
            r_s0_p    <= HRW'(c_p);

            // a row entry sets the table row for the columns behind it
            if (r_s0_act && r_s0_row) begin
                r_ty  <= PXW'(c_idx);
                r_py  <= r_s0_p;
                r_yok <= r_s0_ok && c_idx_ok;
            end
            r_s1_act  <= r_s0_act && !r_s0_row;
            r_s1_ok   <= r_s0_ok && c_idx_ok && r_yok;
            r_s1_last <= r_s0_last;
            r_s1_tx   <= PXW'(c_idx);
            r_s1_px   <= r_s0_p;
            r_s1_ty   <= r_ty;
            r_s1_py   <= r_py;

            r_s2_act  <= r_s1_act;
            r_s2_ok   <= r_s1_ok;
            r_s2_last <= r_s1_last;

            r_s3_act  <= r_s2_act;
            r_s3_last <= r_s2_last;
            r_prod    <= r_s2_ok ? 32'(r_psf_q) * 32'(r_img_q) : 32'd0;

            if (r_s3_act) begin
                if (r_s3_last) begin
                    r_res     <= (c_sum[AW-1:32] != '0) ? 32'hFFFF_FFFF : c_sum[31:0];
                    r_res_rdy <= 1'b1;
                    r_acc     <= '0;
                end else begin
                    r_acc <= c_sum;
                end
            end
            if (c_emit) begin
                r_res_rdy <= 1'b0;
            end
        end
    end

    `PSFWD_ASSERT_SAME(a_res_only_drain, r_res_rdy, r_state == S_DRAIN, "result pending outside drain")
    `PSFWD_ASSERT_NEXT(a_last_gives_res, r_s3_act && r_s3_last, r_res_rdy, "final term did not post a result")
    `PSFWD_ASSERT_NEXT(a_compute_starts, in_acc && i_in_data.mode == psfwd_pkg::MODE_COMPUTE, r_state == S_ROW, "compute item did not start a window")
    `PSFWD_ASSERT_SAME(a_out_from_drain, $rose(r_out_valid), $past(r_state == S_DRAIN), "output raised outside drain")

endmodule
